>>> hw/rtl/rbt_pkg.sv
// Replay buffer table: shared constants, codes and structs.
// Used by every file of the block; depends on nothing.
`timescale 1ns / 1ps

package rbt_pkg;

	// Table geometry
	localparam int DEPTH   = 16;
	localparam int ID_BITS = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int BYTE_W  = 20;

	// Field widths of the channels
	localparam int OP_W   = 4;
	localparam int CFG_IW = 8;

	// Opcodes
	localparam logic [OP_W-1:0] OP_STORE     = 4'd0;
	localparam logic [OP_W-1:0] OP_REPLAY    = 4'd1;
	localparam logic [OP_W-1:0] OP_REMOVE    = 4'd2;
	localparam logic [OP_W-1:0] OP_QUERY     = 4'd3;
	localparam logic [OP_W-1:0] OP_PURGE_EXP = 4'd4;
	localparam logic [OP_W-1:0] OP_PURGE_OLD = 4'd5;
	localparam logic [OP_W-1:0] OP_TRIM      = 4'd6;
	localparam logic [OP_W-1:0] OP_CLEAR     = 4'd7;
	localparam logic [OP_W-1:0] OP_TICK      = 4'd8;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;
	localparam logic [1:0] ST_TOO_SOON  = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_MAX_ENTRIES = 8'd0;
	localparam logic [CFG_IW-1:0] CFG_MAX_REPLAYS = 8'd1;
	localparam logic [CFG_IW-1:0] CFG_REPLAY_GAP  = 8'd2;
	localparam logic [CFG_IW-1:0] CFG_MAX_AGE     = 8'd3;

	// Use-order commands from the sequencer
	typedef struct packed {
		logic             clear;
		logic             alloc;
		logic             drop;
		logic             newest;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] rank_val;
	} rbt_order_cmd_t;

	// Use-order status back to the sequencer
	typedef struct packed {
		logic [DEPTH-1:0] valid;
		logic             oldest_ok;
		logic [IDX_W-1:0] oldest_idx;
		logic             free_ok;
		logic [IDX_W-1:0] free_idx;
	} rbt_order_sts_t;

	// One result transaction
	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] kind_out;
		logic [15:0] size_out;
		logic [7:0]  replays_done;
		logic        evicted_valid;
		logic [31:0] evicted_id;
		logic [4:0]  removed_count;
		logic [4:0]  entry_count;
		logic [19:0] total_bytes;
	} rbt_result_t;

endpackage

>>> hw/rtl/rbt_ifs.sv
// Replay buffer table: request, result and configuration channel interfaces.
// Depends on rbt_pkg for field widths.
`timescale 1ns / 1ps

interface rbt_req_if;
	logic                          valid;
	logic                          ready;
	logic [rbt_pkg::OP_W-1:0]      opcode;
	logic [31:0]                   msg_id;
	logic [31:0]                   message_kind;
	logic [15:0]                   payload_size;
	logic [31:0]                   limit;
	modport source (output valid, opcode, msg_id, message_kind, payload_size, limit,
		input ready);
	modport sink (input valid, opcode, msg_id, message_kind, payload_size, limit,
		output ready);
endinterface

interface rbt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        found;
	logic [31:0] kind_out;
	logic [15:0] size_out;
	logic [7:0]  replays_done;
	logic        evicted_valid;
	logic [31:0] evicted_id;
	logic [4:0]  removed_count;
	logic [4:0]  entry_count;
	logic [19:0] total_bytes;
	modport source (output valid, status, found, kind_out, size_out, replays_done,
		evicted_valid, evicted_id, removed_count, entry_count, total_bytes, input ready);
	modport sink (input valid, status, found, kind_out, size_out, replays_done,
		evicted_valid, evicted_id, removed_count, entry_count, total_bytes, output ready);
endinterface

interface rbt_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [rbt_pkg::CFG_IW-1:0] index;
	logic [31:0]                data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/rbt_order.sv
// Replay buffer table: entry valid bits and use-order ranks.
// Finds the least recently used and the first free entry. Depends on rbt_pkg.
`timescale 1ns / 1ps

module rbt_order (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rbt_pkg::rbt_order_cmd_t cmd,
	output rbt_pkg::rbt_order_sts_t sts
);

	logic [rbt_pkg::DEPTH-1:0] valid_q;
	logic [rbt_pkg::IDX_W-1:0] rank_q [rbt_pkg::DEPTH];
	logic [rbt_pkg::IDX_W-1:0] gap_rank;

	// rank whose gap closes on drop or promote
	assign gap_rank = rank_q[cmd.idx];

	// valid bits and ranks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (cmd.alloc) begin
			valid_q[cmd.idx] <= 1'b1;
		end else if (cmd.drop) begin
			valid_q[cmd.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < rbt_pkg::DEPTH; j++) begin
			if (cmd.alloc && cmd.idx == rbt_pkg::IDX_W'(j)) begin
				rank_q[j] <= cmd.rank_val;
			end else if (cmd.newest && cmd.idx == rbt_pkg::IDX_W'(j)) begin
				rank_q[j] <= cmd.rank_val;
			end else if ((cmd.drop || cmd.newest) && !cmd.clear && valid_q[j] &&
					rank_q[j] > gap_rank) begin
				rank_q[j] <= rank_q[j] - 1'b1;
			end
		end
	end

	// oldest and free finders, lowest index first
	always_comb begin
		sts.valid      = valid_q;
		sts.oldest_ok  = 1'b0;
		sts.oldest_idx = '0;
		sts.free_ok    = 1'b0;
		sts.free_idx   = '0;
		for (int j = rbt_pkg::DEPTH - 1; j >= 0; j--) begin
			if (valid_q[j] && rank_q[j] == '0) begin
				sts.oldest_ok  = 1'b1;
				sts.oldest_idx = rbt_pkg::IDX_W'(j);
			end
			if (!valid_q[j]) begin
				sts.free_ok  = 1'b1;
				sts.free_idx = rbt_pkg::IDX_W'(j);
			end
		end
	end

endmodule

>>> hw/rtl/replay_buffer_table_unit.sv
// Replay buffer table top level: sequencer, entry fields and result register.
// Depends on rbt_pkg, rbt_ifs and rbt_order.
`timescale 1ns / 1ps

// One transaction at a time passes through a sequencer that reads one table entry per cycle
// through a single shared read port and compare unit. Store, replay, remove and query scan
// for the id, one entry a cycle, stopping at the hit, then carry out the operation in the
// operation state and load the result in the done state; a store into a new slot evicts
// the oldest entries one at a time as needed and then allocates. Both purges walk all DEPTH
// entries; trim removes the oldest entries one at a time; clear, tick and unused opcodes
// go straight from the operation state to the done state. The sequencer then returns to
// idle, where the next request is taken. The result sits in an output register, so the
// next request is taken while it waits; that request holds in the done state until the
// earlier result has been taken. Valid bits are flip-flops cleared by reset and ranks
// are only read for valid entries; no clearing pass is needed.
module replay_buffer_table_unit (
	input logic        clk,
	input logic        arst_n,
	rbt_req_if.sink    req,
	rbt_rsp_if.source  rsp,
	rbt_cfg_if.sink    cfg
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOOK  = 7'b0000010,
		S_OP    = 7'b0000100,
		S_EVICT = 7'b0001000,
		S_PURGE = 7'b0010000,
		S_TRIM  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0]  max_entries_q;
	logic [7:0]  max_replays_q;
	logic [15:0] replay_gap_q;
	logic [31:0] max_age_q;

	// request fields
	logic [rbt_pkg::OP_W-1:0]    op_q;
	logic [rbt_pkg::ID_BITS-1:0] id_q;
	logic [31:0]                 kind_in_q;
	logic [15:0]                 size_in_q;
	logic [31:0]                 limit_q;

	// table scalars
	logic [31:0]                now_q;
	logic [rbt_pkg::CNT_W-1:0]  count_q;
	logic [rbt_pkg::BYTE_W-1:0] bytes_q;

	// sequencer
	logic [rbt_pkg::IDX_W-1:0] idx_q;
	logic [rbt_pkg::IDX_W-1:0] hit_q;
	logic                      found_q;

	// partial result
	logic [1:0]  status_q;
	logic [31:0] res_kind_q;
	logic [15:0] res_size_q;
	logic [7:0]  res_repl_q;
	logic        ev_valid_q;
	logic [31:0] ev_id_q;
	logic [4:0]  removed_q;

	rbt_pkg::rbt_result_t out_q;
	logic                 out_valid_q;

	// entry fields, one shared read port
	logic [rbt_pkg::ID_BITS-1:0] ent_id_q    [rbt_pkg::DEPTH];
	logic [31:0]                 ent_kind_q  [rbt_pkg::DEPTH];
	logic [15:0]                 ent_size_q  [rbt_pkg::DEPTH];
	logic [31:0]                 ent_stamp_q [rbt_pkg::DEPTH];
	logic [7:0]                  ent_repl_q  [rbt_pkg::DEPTH];
	logic [31:0]                 ent_last_q  [rbt_pkg::DEPTH];
	logic                        ent_ever_q  [rbt_pkg::DEPTH];

	rbt_pkg::rbt_order_cmd_t ord_cmd;
	rbt_pkg::rbt_order_sts_t ord_sts;

	logic [rbt_pkg::IDX_W-1:0]   rd_idx;
	logic [rbt_pkg::ID_BITS-1:0] rd_id;
	logic [31:0]                 rd_kind;
	logic [15:0]                 rd_size;
	logic [31:0]                 rd_stamp;
	logic [7:0]                  rd_repl;
	logic [31:0]                 rd_last;
	logic                        rd_ever;

	logic                      req_fire;
	logic                      cfg_fire;
	logic [rbt_pkg::CNT_W-1:0] cap;
	logic                      evict_go;
	logic                      trim_go;
	logic                      match;
	logic [31:0]               age;
	logic                      kill;
	logic                      rep_limit;
	logic                      rep_soon;
	logic                      rep_ok;
	logic                      do_rewrite;
	logic                      do_replay;
	logic                      do_alloc;
	logic                      out_free;

	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;

	// shared read port
	always_comb begin
		unique case (state_q) inside
			S_LOOK, S_PURGE: rd_idx = idx_q;
			S_OP:            rd_idx = hit_q;
			default:         rd_idx = ord_sts.oldest_idx;
		endcase
	end

	assign rd_id    = ent_id_q[rd_idx];
	assign rd_kind  = ent_kind_q[rd_idx];
	assign rd_size  = ent_size_q[rd_idx];
	assign rd_stamp = ent_stamp_q[rd_idx];
	assign rd_repl  = ent_repl_q[rd_idx];
	assign rd_last  = ent_last_q[rd_idx];
	assign rd_ever  = ent_ever_q[rd_idx];

	// capacity: zero acts as one, clamp at DEPTH
	always_comb begin
		if (max_entries_q == '0) begin
			cap = rbt_pkg::CNT_W'(1);
		end else if (rbt_pkg::CNT_W'(max_entries_q) > rbt_pkg::CNT_W'(rbt_pkg::DEPTH) ||
				32'(max_entries_q) > 32'(rbt_pkg::DEPTH)) begin
			cap = rbt_pkg::CNT_W'(rbt_pkg::DEPTH);
		end else begin
			cap = rbt_pkg::CNT_W'(max_entries_q);
		end
	end

	// shared compare unit decisions
	assign match     = ord_sts.valid[rd_idx] && rd_id == id_q;
	assign age       = now_q - rd_stamp;
	assign kill      = ord_sts.valid[rd_idx] && ((op_q == rbt_pkg::OP_PURGE_EXP) ?
		(age > max_age_q || rd_repl >= max_replays_q) : (age > limit_q));
	assign evict_go  = count_q >= cap && ord_sts.oldest_ok;
	assign trim_go   = 32'(count_q) > limit_q && ord_sts.oldest_ok;
	assign rep_limit = rd_repl >= max_replays_q;
	assign rep_soon  = rd_ever && (now_q - rd_last) < {16'd0, replay_gap_q};
	assign rep_ok    = !rep_limit && !rep_soon;

	assign do_rewrite = state_q == S_OP && op_q == rbt_pkg::OP_STORE && found_q;
	assign do_replay  = state_q == S_OP && op_q == rbt_pkg::OP_REPLAY && found_q && rep_ok;
	assign do_alloc   = state_q == S_EVICT && !evict_go && ord_sts.free_ok;

	// use-order commands
	always_comb begin
		ord_cmd.clear    = state_q == S_OP && op_q == rbt_pkg::OP_CLEAR;
		ord_cmd.alloc    = do_alloc;
		ord_cmd.newest   = do_rewrite || do_replay;
		ord_cmd.drop     = (state_q == S_EVICT && evict_go) || (state_q == S_TRIM && trim_go) ||
			(state_q == S_PURGE && kill) ||
			(state_q == S_OP && op_q == rbt_pkg::OP_REMOVE && found_q);
		ord_cmd.idx      = do_alloc ? ord_sts.free_idx : rd_idx;
		ord_cmd.rank_val = do_alloc ? rbt_pkg::IDX_W'(count_q) :
			rbt_pkg::IDX_W'(count_q - 1'b1);
	end

	rbt_order u_order (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ord_cmd),
		.sts    (ord_sts)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= 5'd16;
			max_replays_q <= 8'd3;
			replay_gap_q  <= 16'd500;
			max_age_q     <= 32'd600000;
		end else if (cfg_fire) begin
			unique case (cfg.index)
				rbt_pkg::CFG_MAX_ENTRIES: max_entries_q <= cfg.data[4:0];
				rbt_pkg::CFG_MAX_REPLAYS: max_replays_q <= cfg.data[7:0];
				rbt_pkg::CFG_REPLAY_GAP:  replay_gap_q  <= cfg.data[15:0];
				rbt_pkg::CFG_MAX_AGE:     max_age_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// entry field writes
	always_ff @(posedge clk) begin
		if (do_alloc) begin
			ent_id_q[ord_sts.free_idx]    <= id_q;
			ent_kind_q[ord_sts.free_idx]  <= kind_in_q;
			ent_size_q[ord_sts.free_idx]  <= size_in_q;
			ent_stamp_q[ord_sts.free_idx] <= now_q;
			ent_repl_q[ord_sts.free_idx]  <= '0;
			ent_last_q[ord_sts.free_idx]  <= '0;
			ent_ever_q[ord_sts.free_idx]  <= 1'b0;
		end else if (do_rewrite) begin
			ent_kind_q[hit_q]  <= kind_in_q;
			ent_size_q[hit_q]  <= size_in_q;
			ent_stamp_q[hit_q] <= now_q;
			ent_repl_q[hit_q]  <= '0;
			ent_last_q[hit_q]  <= '0;
			ent_ever_q[hit_q]  <= 1'b0;
		end else if (do_replay) begin
			ent_repl_q[hit_q] <= rd_repl + 1'b1;
			ent_last_q[hit_q] <= now_q;
			ent_ever_q[hit_q] <= 1'b1;
		end
	end

	// request fields and result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q      <= req.opcode;
			id_q      <= req.msg_id[rbt_pkg::ID_BITS-1:0];
			kind_in_q <= req.message_kind;
			size_in_q <= req.payload_size;
			limit_q   <= req.limit;
		end
		if (state_q == S_DONE && out_free) begin
			out_q.status        <= status_q;
			out_q.found         <= found_q;
			out_q.kind_out      <= res_kind_q;
			out_q.size_out      <= res_size_q;
			out_q.replays_done  <= res_repl_q;
			out_q.evicted_valid <= ev_valid_q;
			out_q.evicted_id    <= ev_id_q;
			out_q.removed_count <= removed_q;
			out_q.entry_count   <= 5'(count_q);
			out_q.total_bytes   <= bytes_q;
		end
	end

	// sequencer and table scalars
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			now_q       <= '0;
			count_q     <= '0;
			bytes_q     <= '0;
			idx_q       <= '0;
			hit_q       <= '0;
			found_q     <= 1'b0;
			status_q    <= rbt_pkg::ST_OK;
			res_kind_q  <= '0;
			res_size_q  <= '0;
			res_repl_q  <= '0;
			ev_valid_q  <= 1'b0;
			ev_id_q     <= '0;
			removed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded on completion, cleared once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			// count and byte total follow the use-order commands
			if (ord_cmd.drop) begin
				count_q   <= count_q - 1'b1;
				bytes_q   <= bytes_q - rbt_pkg::BYTE_W'(rd_size);
				removed_q <= removed_q + 1'b1;
			end else if (do_alloc) begin
				count_q <= count_q + 1'b1;
				bytes_q <= bytes_q + rbt_pkg::BYTE_W'(size_in_q);
			end else if (do_rewrite) begin
				bytes_q <= bytes_q - rbt_pkg::BYTE_W'(rd_size) + rbt_pkg::BYTE_W'(size_in_q);
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						idx_q      <= '0;
						found_q    <= 1'b0;
						status_q   <= rbt_pkg::ST_OK;
						res_kind_q <= '0;
						res_size_q <= '0;
						res_repl_q <= '0;
						ev_valid_q <= 1'b0;
						ev_id_q    <= '0;
						removed_q  <= '0;
						state_q    <= (req.opcode <= rbt_pkg::OP_QUERY) ? S_LOOK : S_OP;
					end
				end
				S_LOOK: begin
					if (match) begin
						hit_q   <= idx_q;
						found_q <= 1'b1;
						state_q <= S_OP;
					end else if (idx_q == rbt_pkg::IDX_W'(rbt_pkg::DEPTH - 1)) begin
						state_q <= S_OP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_OP: begin
					state_q <= S_DONE;
					unique case (op_q) inside
						rbt_pkg::OP_STORE: begin
							if (!found_q) begin
								state_q <= S_EVICT;
							end
						end
						rbt_pkg::OP_REPLAY: begin
							if (!found_q) begin
								status_q <= rbt_pkg::ST_NOT_FOUND;
							end else begin
								res_kind_q <= rd_kind;
								res_size_q <= rd_size;
								if (rep_limit) begin
									status_q   <= rbt_pkg::ST_LIMIT;
									res_repl_q <= rd_repl;
								end else if (rep_soon) begin
									status_q   <= rbt_pkg::ST_TOO_SOON;
									res_repl_q <= rd_repl;
								end else begin
									res_repl_q <= rd_repl + 1'b1;
								end
							end
						end
						rbt_pkg::OP_REMOVE, rbt_pkg::OP_QUERY: begin
							if (!found_q) begin
								status_q <= rbt_pkg::ST_NOT_FOUND;
							end else begin
								res_kind_q <= rd_kind;
								res_size_q <= rd_size;
								res_repl_q <= rd_repl;
							end
						end
						rbt_pkg::OP_PURGE_EXP, rbt_pkg::OP_PURGE_OLD: begin
							idx_q   <= '0;
							state_q <= S_PURGE;
						end
						rbt_pkg::OP_TRIM: begin
							state_q <= S_TRIM;
						end
						rbt_pkg::OP_CLEAR: begin
							removed_q <= 5'(count_q);
							count_q   <= '0;
							bytes_q   <= '0;
						end
						rbt_pkg::OP_TICK: begin
							now_q <= now_q + 1'b1;
						end
						default: ;
					endcase
				end
				S_EVICT: begin
					// drop the oldest until below capacity, then allocate
					if (evict_go) begin
						if (!ev_valid_q) begin
							ev_valid_q <= 1'b1;
							ev_id_q    <= 32'(rd_id);
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PURGE: begin
					if (idx_q == rbt_pkg::IDX_W'(rbt_pkg::DEPTH - 1)) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_TRIM: begin
					if (!trim_go) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result channel
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.found         = out_q.found;
	assign rsp.kind_out      = out_q.kind_out;
	assign rsp.size_out      = out_q.size_out;
	assign rsp.replays_done  = out_q.replays_done;
	assign rsp.evicted_valid = out_q.evicted_valid;
	assign rsp.evicted_id    = out_q.evicted_id;
	assign rsp.removed_count = out_q.removed_count;
	assign rsp.entry_count   = out_q.entry_count;
	assign rsp.total_bytes   = out_q.total_bytes;

	// checks
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(ord_sts.valid) == 32'(count_q))
		else $error("entry count differs from valid bits");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(rbt_pkg::DEPTH))
		else $error("entry count above table depth");

	a_drop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ord_cmd.drop |-> ord_sts.valid[ord_cmd.idx])
		else $error("dropping an empty entry");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVICT && !evict_go) |-> ord_sts.free_ok)
		else $error("no free entry for store");

	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> out_valid_q)
		else $error("finished transaction not presented");

endmodule
